[src/rrf_pkg.sv]
package rrf_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_ELEM_TYPE     = 3'd0,
      REG_LITTLE_ENDIAN = 3'd1,
      REG_RANGE_MIN     = 3'd2,
      REG_RANGE_MAX     = 3'd3,
      REG_MIN_RUN       = 3'd4,
      REG_START_OFFSET  = 3'd5
   } reg_index_type;

   // Element type codes
   localparam logic [3:0] TYPE_SINGLE = 4'd8;
   localparam logic [3:0] TYPE_DOUBLE = 4'd9;

   // Element size codes: bytes = 1 << code
   typedef logic [1:0] size_code_type;

   // Settings the range compare needs
   typedef struct packed {
      logic [3:0]  elem_type;
      logic        little_endian;
      logic [63:0] range_min;
      logic [63:0] range_max;
   } cmp_cfg_type;

   // Effective type: undefined codes act as u8
   function automatic logic [3:0] eff_type(input logic [3:0] t);
      return (t > TYPE_DOUBLE) ? 4'd0 : t;
   endfunction

   function automatic size_code_type size_of(input logic [3:0] t);
      logic [3:0] e;
      e = eff_type(t);
      if (e == TYPE_SINGLE) return 2'd2;
      if (e == TYPE_DOUBLE) return 2'd3;
      return e[2:1];
   endfunction

   // Byte mask of an element, minus one of its byte count
   function automatic logic [2:0] size_mask(input size_code_type sz);
      return 3'((4'd1 << sz) - 4'd1);
   endfunction

endpackage

[src/range_run_finder.sv]
// Range run finder: scans a byte stream for the earliest element start after
// start_offset where min_run consecutive elements (1/2/4/8 bytes, int or IEEE
// float) lie within [range_min, range_max]. One result per buffer: on the
// matching byte, or a not-found result on the last byte. Throughput is one
// byte per cycle while rsp_tready does not hold the result register. The
// byte sits in the input register, then compare and run-counter update go
// into the result register, so rsp_tvalid rises after both registers. The
// per-alignment run counter read-modify-write is the loop that limits it.
module range_run_finder
   import rrf_pkg::*;
#(
   parameter int POS_BITS = 32,
   parameter int RUN_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // last_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] match_pos
   output logic        rsp_tuser     // [0] found
);

   localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

   // Configuration registers
   cmp_cfg_type cfg_ff;
   logic [31:0] min_run_ff;
   logic [31:0] start_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.elem_type     <= '0;
         cfg_ff.little_endian <= 1'b1;
         cfg_ff.range_min     <= '0;
         cfg_ff.range_max     <= '0;
         min_run_ff           <= 32'd1;
         start_offset_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ELEM_TYPE:     cfg_ff.elem_type     <= csr_wdata[3:0];
            REG_LITTLE_ENDIAN: cfg_ff.little_endian <= csr_wdata[0];
            REG_RANGE_MIN:     cfg_ff.range_min     <= csr_wdata;
            REG_RANGE_MAX:     cfg_ff.range_max     <= csr_wdata;
            REG_MIN_RUN:       min_run_ff           <= csr_wdata[31:0];
            REG_START_OFFSET:  start_offset_ff      <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Flow control
   logic s0_valid_ff;
   logic [7:0] s0_byte_ff;
   logic s0_last_ff;
   logic rsp_valid_ff, rsp_found_ff;
   logic [31:0] rsp_pos_ff;
   logic adv, fire;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s0_valid_ff || adv;
   assign fire       = s0_valid_ff && adv;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s0_valid_ff <= 1'b1;
      end else if (adv) begin
         s0_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s0_byte_ff <= req_tdata;
         s0_last_ff <= req_tlast;
      end
   end

   // Search state
   logic [63:0]         window_ff;
   logic [POS_BITS-1:0] pos_ff;
   logic [RUN_BITS-1:0] run_count_ff [8];
   logic [POS_BITS-1:0] run_begin_ff [8];
   logic                done_ff;

   logic [63:0]         window_in;
   logic                elem_ok;
   logic [2:0]          smask;
   logic [2:0]          align;
   logic [POS_BITS-1:0] elem_start;
   logic                elem_valid;
   logic [RUN_BITS-1:0] cnt_cur, cnt_in;
   logic [POS_BITS-1:0] beg_in;
   logic                hit;
   logic [POS_BITS-1:0] hit_pos;
   logic                give;

   assign window_in = {window_ff[55:0], s0_byte_ff};

   rrf_in_range u_in_range (
      .window   (window_in),
      .cfg      (cfg_ff),
      .in_range (elem_ok)
   );

   assign smask      = size_mask(size_of(cfg_ff.elem_type));
   assign align      = pos_ff[2:0] & smask;
   assign elem_start = pos_ff - POS_BITS'(smask);
   assign elem_valid = (pos_ff >= POS_BITS'(smask)) &&
                       (32'(elem_start) > start_offset_ff);
   assign cnt_cur    = run_count_ff[align];

   // Run update and match decision
   always_comb begin
      cnt_in  = cnt_cur;
      beg_in  = run_begin_ff[align];
      hit     = 1'b0;
      hit_pos = '0;
      if (min_run_ff == '0) begin
         hit     = 32'(pos_ff) > start_offset_ff;
         hit_pos = pos_ff;
      end else if (elem_valid) begin
         if (elem_ok) begin
            if (cnt_cur == '0) beg_in = elem_start;
            if (cnt_cur != RUN_MAX) cnt_in = cnt_cur + 1'b1;
            hit     = 32'(cnt_in) >= min_run_ff;
            hit_pos = beg_in;
         end else begin
            cnt_in = '0;
         end
      end
   end

   assign give = !done_ff && (hit || s0_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         done_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            run_count_ff[i] <= '0;
            run_begin_ff[i] <= '0;
         end
      end else if (fire) begin
         if (s0_last_ff) begin
            window_ff <= '0;
            pos_ff    <= '0;
            done_ff   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
               run_count_ff[i] <= '0;
               run_begin_ff[i] <= '0;
            end
         end else begin
            window_ff <= window_in;
            pos_ff    <= pos_ff + 1'b1;
            if (!done_ff) begin
               if (hit) done_ff <= 1'b1;
               if (min_run_ff != '0 && elem_valid) begin
                  run_count_ff[align] <= cnt_in;
                  run_begin_ff[align] <= beg_in;
               end
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fire && give;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && give) begin
         rsp_found_ff <= hit;
         rsp_pos_ff   <= hit ? 32'(hit_pos) : 32'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pos_ff;
   assign rsp_tuser  = rsp_found_ff;

   // Checks
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_pos_ff == '0)
      else $error("not-found result carries a position");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff && s0_valid_ff)
      else $error("input stalled without a waiting result");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      fire && done_ff && !s0_last_ff |=> !(rsp_valid_ff && $changed(rsp_pos_ff)) || !done_ff)
      else $error("result after search completed");

endmodule

[src/rrf_in_range.sv]
// Assembles the newest element from the byte window and checks it
// against the configured bounds.
module rrf_in_range
   import rrf_pkg::*;
(
   input  logic [63:0] window,
   input  cmp_cfg_type cfg,
   output logic        in_range
);

   // Ordered key of an integer: extend to 64 bits, flip the sign bit if signed
   function automatic logic [63:0] int_key(input logic [63:0] x, input size_code_type sz,
                                           input logic sgn);
      logic [63:0] r;
      logic        sb;
      unique case (sz)
         2'd0: begin sb = x[7];  r = {56'd0, x[7:0]};  end
         2'd1: begin sb = x[15]; r = {48'd0, x[15:0]}; end
         2'd2: begin sb = x[31]; r = {32'd0, x[31:0]}; end
         default: begin sb = x[63]; r = x; end
      endcase
      if (sgn) begin
         unique case (sz)
            2'd0: r[63:8]  = {56{sb}};
            2'd1: r[63:16] = {48{sb}};
            2'd2: r[63:32] = {32{sb}};
            default: ;
         endcase
         r[63] = ~r[63];
      end
      return r;
   endfunction

   // Float patterns aligned to the top of 64 bits
   function automatic logic [63:0] flt_align(input logic [63:0] x, input logic dbl);
      return dbl ? x : {x[31:0], 32'd0};
   endfunction

   function automatic logic [63:0] flt_key(input logic [63:0] x);
      return x[63] ? ~x : {1'b1, x[62:0]};
   endfunction

   function automatic logic flt_nan(input logic [63:0] x, input logic dbl);
      if (dbl) return (&x[62:52]) && (|x[51:0]);
      return (&x[62:55]) && (|x[54:32]);
   endfunction

   logic [3:0]    etype;
   size_code_type sz;
   logic [2:0]    smask;
   logic [63:0]   elem;
   logic          is_float;
   logic          is_dbl;
   logic [63:0]   fv, flo, fhi;
   logic [63:0]   kv, klo, khi;
   logic          zero_lo, zero_hi;
   logic          ge_lo, le_hi;

   assign etype    = eff_type(cfg.elem_type);
   assign sz       = size_of(cfg.elem_type);
   assign smask    = size_mask(sz);
   assign is_float = (etype == TYPE_SINGLE) || (etype == TYPE_DOUBLE);
   assign is_dbl   = (etype == TYPE_DOUBLE);

   // Element assembly; the newest byte is the last byte in memory order
   always_comb begin
      elem = '0;
      for (int k = 0; k < 8; k++) begin
         if (3'(k) <= smask) begin
            if (cfg.little_endian) begin
               elem[8*k +: 8] = window[8*(smask - 3'(k)) +: 8];
            end else begin
               elem[8*k +: 8] = window[8*k +: 8];
            end
         end
      end
   end

   // Ordered keys
   assign fv  = flt_align(elem, is_dbl);
   assign flo = flt_align(cfg.range_min, is_dbl);
   assign fhi = flt_align(cfg.range_max, is_dbl);

   always_comb begin
      if (is_float) begin
         kv  = flt_key(fv);
         klo = flt_key(flo);
         khi = flt_key(fhi);
      end else begin
         kv  = int_key(elem, sz, etype[0]);
         klo = int_key(cfg.range_min, sz, etype[0]);
         khi = int_key(cfg.range_max, sz, etype[0]);
      end
   end

   // Signed zeros compare equal
   assign zero_lo = is_float && (fv[62:0] == '0) && (flo[62:0] == '0);
   assign zero_hi = is_float && (fv[62:0] == '0) && (fhi[62:0] == '0);
   assign ge_lo   = zero_lo || (kv >= klo);
   assign le_hi   = zero_hi || (kv <= khi);

   assign in_range = ge_lo && le_hi &&
                     !(is_float && (flt_nan(fv, is_dbl) || flt_nan(flo, is_dbl) ||
                                    flt_nan(fhi, is_dbl)));

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
   import rrf_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } buf_byte_type;

   typedef struct {
      logic        found;
      logic [31:0] pos;
   } search_result_type;

   localparam int TIMEOUT_CYCLES = 400000;
   localparam logic [31:0] RUN_SAT = 32'hFFFF_FFFF;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] match_pos
   logic        rsp_tuser;    // [0] found

   range_run_finder u_top (.*);

   // predictor copy of the configuration
   logic [3:0]  cfg_type;
   logic        cfg_le;
   logic [63:0] cfg_min;
   logic [63:0] cfg_max;
   logic [31:0] cfg_min_run;
   logic [31:0] cfg_start;

   // predictor copy of the scan state
   logic [63:0] win;
   logic [31:0] scan_pos;
   logic [31:0] run_cnt [8];
   logic [31:0] run_beg [8];
   logic        reported;

   buf_byte_type      byte_q [$];
   search_result_type result_q [$];
   int             idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
   int             errors;
   int             cycles;
   logic           took;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic bit roll(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic int elem_bytes(input logic [3:0] t);
      logic [3:0] e;
      e = (t > TYPE_DOUBLE) ? 4'd0 : t;
      if (e == TYPE_SINGLE) return 4;
      if (e == TYPE_DOUBLE) return 8;
      return 1 << e[2:1];
   endfunction

   function automatic logic [63:0] byte_mask(input int s);
      return (s >= 8) ? '1 : ((64'd1 << (s * 8)) - 64'd1);
   endfunction

   // IEEE ordering key; both zeros map to the same key
   function automatic logic [63:0] float_key(input logic [63:0] v, input int w);
      logic [63:0] m;
      logic [63:0] sgn;
      m = byte_mask(w / 8);
      sgn = 64'd1 << (w - 1);
      v = v & m;
      if ((v & ~sgn) == 0) return sgn;
      if (v & sgn) return ~v & m;
      return v | sgn;
   endfunction

   function automatic bit is_nan(input logic [63:0] v, input int w);
      if (w == 32) return v[30:23] == 8'hFF && v[22:0] != 0;
      return v[62:52] == 11'h7FF && v[51:0] != 0;
   endfunction

   // a <= b under the element type's ordering
   function automatic bit elem_le(input logic [63:0] a, input logic [63:0] b,
                                  input logic [3:0] t);
      int s;
      logic [63:0] m;
      logic [63:0] sa;
      logic [63:0] sb;
      s = elem_bytes(t);
      m = byte_mask(s);
      if (t == TYPE_SINGLE || t == TYPE_DOUBLE) begin
         if (is_nan(a, s * 8) || is_nan(b, s * 8)) return 1'b0;
         return float_key(a, s * 8) <= float_key(b, s * 8);
      end
      if (t <= TYPE_DOUBLE && t[0]) begin
         sa = a & m;
         sb = b & m;
         if (s < 8 && sa[s*8-1]) sa = sa | ~m;
         if (s < 8 && sb[s*8-1]) sb = sb | ~m;
         return $signed(sa) <= $signed(sb);
      end
      return (a & m) <= (b & m);
   endfunction

   function automatic bit elem_in_range(input logic [63:0] v);
      return elem_le(cfg_min, v, cfg_type) && elem_le(v, cfg_max, cfg_type);
   endfunction

   function void clear_scan();
      win = '0;
      scan_pos = '0;
      reported = 1'b0;
      for (int i = 0; i < 8; i++) begin
         run_cnt[i] = '0;
         run_beg[i] = '0;
      end
   endfunction

   // advance the scan by one byte, queueing any result it produces
   function void scan_byte(input logic [7:0] d, input logic last);
      int s;
      int a;
      logic [31:0] st;
      logic [63:0] raw;
      logic [63:0] v;
      logic hit;
      logic [31:0] hit_pos;
      search_result_type r;
      win = {win[55:0], d};
      hit = 1'b0;
      hit_pos = '0;
      if (!reported) begin
         s = elem_bytes(cfg_type);
         if (cfg_min_run == 0) begin
            if (scan_pos > cfg_start) begin
               hit = 1'b1;
               hit_pos = scan_pos;
            end
         end else if (scan_pos >= s - 1) begin
            st = scan_pos - (s - 1);
            if (st > cfg_start) begin
               a = scan_pos & (s - 1);
               raw = win & byte_mask(s);
               v = raw;
               if (cfg_le) begin
                  v = '0;
                  for (int k = 0; k < s; k++) v = (v << 8) | ((raw >> (8 * k)) & 64'hFF);
               end
               if (elem_in_range(v)) begin
                  if (run_cnt[a] == 0) run_beg[a] = st;
                  if (run_cnt[a] != RUN_SAT) run_cnt[a] = run_cnt[a] + 1;
                  if (run_cnt[a] >= cfg_min_run) begin
                     hit = 1'b1;
                     hit_pos = run_beg[a];
                  end
               end else begin
                  run_cnt[a] = '0;
               end
            end
         end
         if (hit) begin
            r.found = 1'b1;
            r.pos = hit_pos;
            result_q.insert(result_q.size(), r);
            reported = 1'b1;
         end else if (last) begin
            r.found = 1'b0;
            r.pos = '0;
            result_q.insert(result_q.size(), r);
         end
      end
      scan_pos = scan_pos + 1;
      if (last) clear_scan();
   endfunction

   // predict on each accepted input transaction
   always @(posedge clock) begin
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
      end
   end

   // input driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
      end else begin
         if (took) void'(byte_q.pop_front());
         if (req_tvalid && !took) begin
            // hold the transaction until accepted
         end else if (byte_q.size() > 0 &&
                      !((idle_mode == 1 && roll(84)) || (idle_mode == 3 && roll(7)))) begin
            req_tvalid <= 1'b1;
            req_tdata <= byte_q[0].data;
            req_tlast <= byte_q[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      rsp_tready <= !((idle_mode == 2 && roll(84)) || (idle_mode == 3 && roll(7)));
   end

   // result checker and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("%0t: timeout", $realtime);
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_q.size() == 0) begin
            $display("%0t: unexpected result found=%0b pos=%0d", $realtime,
                     rsp_tuser, rsp_tdata);
            errors <= errors + 1;
         end else begin
            if (rsp_tuser !== result_q[0].found || rsp_tdata !== result_q[0].pos) begin
               $display("%0t: mismatch expected found=%0b pos=%0d actual found=%0b pos=%0d",
                        $realtime, result_q[0].found, result_q[0].pos, rsp_tuser, rsp_tdata);
               errors <= errors + 1;
            end
            void'(result_q.pop_front());
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_ELEM_TYPE:     cfg_type = val[3:0];
         REG_LITTLE_ENDIAN: cfg_le = val[0];
         REG_RANGE_MIN:     cfg_min = val;
         REG_RANGE_MAX:     cfg_max = val;
         REG_MIN_RUN:       cfg_min_run = val[31:0];
         REG_START_OFFSET:  cfg_start = val[31:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [3:0] t, input logic le, input logic [63:0] lo,
                            input logic [63:0] hi, input logic [31:0] runs,
                            input logic [31:0] start);
      write_reg(REG_ELEM_TYPE, {60'd0, t});
      write_reg(REG_LITTLE_ENDIAN, {63'd0, le});
      write_reg(REG_RANGE_MIN, lo);
      write_reg(REG_RANGE_MAX, hi);
      write_reg(REG_MIN_RUN, {32'd0, runs});
      write_reg(REG_START_OFFSET, {32'd0, start});
   endtask

   task automatic push_buffer(input logic [7:0] bytes [$]);
      buf_byte_type b;
      foreach (bytes[i]) begin
         b.data = bytes[i];
         b.last = (i == bytes.size() - 1);
         byte_q.insert(byte_q.size(), b);
      end
   endtask

   // buffer of whole elements, many of them equal to a bound, after a few loose bytes
   task automatic add_elem_buffer(input int nelem, input int pct_in);
      logic [7:0] bytes [$];
      logic [63:0] v;
      int s;
      s = elem_bytes(cfg_type);
      repeat ($urandom_range(s - 1)) bytes.insert(bytes.size(), 8'($urandom));
      repeat (nelem) begin
         case ($urandom_range(3))
            0: v = cfg_min;
            1: v = cfg_max;
            default: v = {$urandom, $urandom};
         endcase
         if (!roll(pct_in)) v = {$urandom, $urandom};
         for (int k = 0; k < s; k++)
            bytes.insert(bytes.size(), cfg_le ? v[8*k +: 8] : v[8*(s-1-k) +: 8]);
      end
      if (bytes.size() == 0) bytes.insert(0, 8'($urandom));
      push_buffer(bytes);
   endtask

   task automatic wait_idle();
      wait (byte_q.size() == 0 && !req_tvalid && result_q.size() == 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      logic [7:0] bytes [$];
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] tmp;
      logic [3:0] t;
      int s;
      errors = 0;
      cycles = 0;
      idle_mode = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_tready = 1'b0;
      cfg_type = 4'd0;
      cfg_le = 1'b1;
      cfg_min = '0;
      cfg_max = '0;
      cfg_min_run = 32'd1;
      cfg_start = '0;
      clear_scan();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: u8 equal to zero, runs of one, after position zero
      bytes = '{8'h00, 8'h00, 8'hFF};
      push_buffer(bytes);
      bytes = '{8'h00};
      push_buffer(bytes);
      bytes = '{8'hFF, 8'h7F, 8'h80, 8'h01};
      push_buffer(bytes);
      wait_idle();

      // zero run length: hits on the first byte past the offset
      configure(4'd0, 1'b1, 64'd0, 64'd0, 32'd0, 32'd2);
      bytes = '{8'h12, 8'h34, 8'h56, 8'h78};
      push_buffer(bytes);
      wait_idle();

      // undefined type code behaves as u8; full range with huge offset matches nothing
      configure(4'd15, 1'b0, 64'd0, '1, 32'd1, 32'hFFFF_FFFF);
      bytes = '{8'hAA, 8'h55, 8'hFF};
      push_buffer(bytes);
      wait_idle();

      // maximum run length: the short buffer cannot match
      configure(4'd1, 1'b0, 64'h80, 64'h7F, 32'hFFFF_FFFF, 32'd0);
      bytes = '{8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01};
      push_buffer(bytes);
      wait_idle();

      // doubles: infinite bounds; NaN values never in range
      configure(TYPE_DOUBLE, 1'b1, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                32'd2, 32'd0);
      bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF8, 8'h7F,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 8'h3F, 8'h00};
      push_buffer(bytes);
      wait_idle();

      // random settings, well-formed element buffers plus noise
      for (int ph = 0; ph < 24; ph++) begin
         idle_mode = ph % 4;
         t = 4'($urandom_range(15));
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
         if (roll(20)) lo = '0;
         if (roll(20)) hi = '1;
         if (!elem_le(lo, hi, t) && roll(80)) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
         end
         configure(t, 1'($urandom_range(1)), lo, hi,
                   roll(10) ? 32'd0 : (roll(5) ? 32'hFFFF_FFFF : $urandom_range(1, 4)),
                   roll(5) ? 32'hFFFF_FFFF : (roll(50) ? 32'd0 : $urandom_range(6)));
         s = elem_bytes(cfg_type);
         repeat (2) begin
            if (roll(85)) begin
               add_elem_buffer($urandom_range(1, 32 / s), 80);
            end else begin
               bytes.delete();
               repeat ($urandom_range(1, 12)) bytes.insert(bytes.size(), 8'($urandom));
               push_buffer(bytes);
            end
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[files.f]
src/rrf_pkg.sv
src/rrf_in_range.sv
src/range_run_finder.sv
sim/tb.sv
